// ===== rtl/fbik_pkg.sv =====
// ----------------------------------------------------------------------------
// fbik_pkg
// Shared types, constants and step-angle table for the five-bar inverse
// kinematics pipeline.
// ----------------------------------------------------------------------------
package fbik_pkg;

  localparam int LEN_WIDTH    = 31;
  localparam int COORD_WIDTH  = 32;
  localparam int MODE_WIDTH   = 2;
  localparam int ANGLE_WIDTH  = 19;

  // CORDIC and angle datapath widths (Q30 radians)
  localparam int CORDIC_STEPS = 30;
  localparam int ZW           = 34;
  localparam int AW           = 36;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [AW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [AW-1:0] TWO_PI_Q30  = 36'sd6746518852;

  // register stages inside one side datapath
  localparam int SIDE_LATENCY = 104;

  typedef enum logic [1:0] {
    REG_DISTAL = 2'd0,
    REG_CRANK  = 2'd1,
    REG_BASE   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [AW-1:0] angle;
    logic                 reach;
  } side_out_t;

  // truncated arctan(2^-i) in Q30
  function automatic logic signed [ZW-1:0] step_angle(input int i);
    logic [63:0] tail;
    tail = (64'd1 << (30 - i)) - 64'd1;
    case (i)
      0:       return 34'sd843314856;
      1:       return 34'sd497837829;
      2:       return 34'sd263043836;
      3:       return 34'sd133525158;
      4:       return 34'sd67021686;
      5:       return 34'sd33543515;
      6:       return 34'sd16775850;
      7:       return 34'sd8388437;
      8:       return 34'sd4194282;
      9:       return 34'sd2097149;
      10:      return 34'sd1048575;
      default: return ZW'(tail);
    endcase
  endfunction

endpackage

// ===== rtl/five_bar_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// five_bar_inverse_kinematics
// Crank angles of a symmetric five-bar linkage for a target end point.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one target item per transfer; tdata = target_x (bits 31:0),
//   target_y (63:32), both signed Q16.16; tuser = elbow_mode (bit 0 left
//   root sign, bit 1 right root sign, 1 = positive).
//   m_axis: one result per target; tdata = left_angle (18:0), right_angle
//   (37:19), signed radians with FRAC_BITS fraction bits; tuser = reachable.
//   Unreachable targets return zero angles with reachable cleared.
//   cfg: cfg_we writes cfg_wdata to register cfg_index (0 distal link,
//   1 crank link, 2 base spacing); write only while the pipeline is empty.
//   The pipeline runs through the 62-stage square root and the 31-stage
//   CORDIC units; one item is accepted every cycle while m_axis is not stalled.
//   Reset empties the pipeline and sets all three lengths to 1.0.
//   When m_axis_tready is low with a result waiting, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module five_bar_inverse_kinematics #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // target stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // target_x, target_y
  input  logic [1:0]  s_axis_tuser,   // elbow_mode
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // left_angle, right_angle, zero pad
  output logic [0:0]  m_axis_tuser,   // reachable
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);

  import fbik_pkg::*;

  localparam int LAT = SIDE_LATENCY + 1;
  localparam int SH  = 30 - FRAC_BITS;
  localparam logic signed [AW-1:0] RND = AW'(1) <<< (SH - 1);

  // configuration registers
  logic [LEN_WIDTH-1:0] distal_len, crank_len, base_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      distal_len <= 31'd65536;
      crank_len  <= 31'd65536;
      base_len   <= 31'd65536;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DISTAL: distal_len <= cfg_wdata;
        REG_CRANK:  crank_len  <= cfg_wdata;
        REG_BASE:   base_len   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // pipeline advance and valid tracking
  logic           en;
  logic [LAT-1:0] vpipe;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vpipe[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[LAT-2:0], s_axis_tvalid};
    end
  end

  // doubled coordinates and lengths
  logic signed [33:0] ul, ur;
  logic signed [32:0] vv;
  logic [31:0]        la2, lb2;

  assign ul  = $signed({s_axis_tdata[31], s_axis_tdata[31:0], 1'b0}) +
               $signed({3'b000, base_len});
  assign ur  = $signed({s_axis_tdata[31], s_axis_tdata[31:0], 1'b0}) -
               $signed({3'b000, base_len});
  assign vv  = $signed({s_axis_tdata[63:32], 1'b0});
  assign la2 = {distal_len, 1'b0};
  assign lb2 = {crank_len, 1'b0};

  side_out_t left_res, right_res;

  fbik_side u_left (
    .clk, .en, .u(ul), .v(vv), .a(la2), .b(lb2), .pos(s_axis_tuser[0]), .res(left_res)
  );

  fbik_side u_right (
    .clk, .en, .u(ur), .v(vv), .a(la2), .b(lb2), .pos(s_axis_tuser[1]), .res(right_res)
  );

  // round to the output format and gate by reachability
  logic signed [AW-1:0] lr, rr;
  logic                 both;

  assign lr   = (left_res.angle + RND) >>> SH;
  assign rr   = (right_res.angle + RND) >>> SH;
  assign both = left_res.reach && right_res.reach;

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata[18:0]  <= both ? lr[ANGLE_WIDTH-1:0] : '0;
      m_axis_tdata[37:19] <= both ? rr[ANGLE_WIDTH-1:0] : '0;
      m_axis_tdata[39:38] <= 2'b00;
      m_axis_tuser[0]     <= both;
    end
  end

  // checks
  a_unreach_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("unreachable result with nonzero angles");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> vpipe[0])
    else $error("accepted item missing from pipeline");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vpipe))
    else $error("valid bits moved during stall");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> vpipe == '0)
    else $error("pipeline not empty after reset");

endmodule

// ===== rtl/fbik_mul.sv =====
// ----------------------------------------------------------------------------
// fbik_mul
// Unsigned W x W multiplier in two stages: four half-width partial
// products, then their shifted sum.
// ----------------------------------------------------------------------------
module fbik_mul #(
  parameter int W = 34
) (
  input  logic           clk,
  input  logic           en,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);

  localparam int L = W / 2;
  localparam int H = W - L;

  logic [2*L-1:0] ll;
  logic [L+H-1:0] lh;
  logic [L+H-1:0] hl;
  logic [2*H-1:0] hh;

  // partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll <= (2*L)'(a[L-1:0]) * (2*L)'(b[L-1:0]);
      lh <= (L+H)'(a[L-1:0]) * (L+H)'(b[W-1:L]);
      hl <= (L+H)'(a[W-1:L]) * (L+H)'(b[L-1:0]);
      hh <= (2*H)'(a[W-1:L]) * (2*H)'(b[W-1:L]);
    end
  end

  // recombine
  always_ff @(posedge clk) begin
    if (en) begin
      p <= (2*W)'(ll) + ((2*W)'(lh) << L) + ((2*W)'(hl) << L) + ((2*W)'(hh) << (2*L));
    end
  end

endmodule

// ===== rtl/fbik_delay.sv =====
// ----------------------------------------------------------------------------
// fbik_delay
// Stallable shift line that keeps side data aligned with the long units.
// ----------------------------------------------------------------------------
module fbik_delay #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [N];

  // shift when the pipeline moves
  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < N; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[N-1];

endmodule

// ===== rtl/fbik_sqrt.sv =====
// ----------------------------------------------------------------------------
// fbik_sqrt
// Pipelined integer floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module fbik_sqrt #(
  parameter int QW = 124,
  parameter int RW = 62
) (
  input  logic          clk,
  input  logic          en,
  input  logic [QW-1:0] radicand,
  output logic [RW-1:0] root
);

  logic [QW-1:0] rem  [RW+1];
  logic [RW-1:0] part [RW+1];

  assign rem[0]  = radicand;
  assign part[0] = '0;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int J = RW - 1 - k;
    logic [QW-1:0] trial;
    logic          take;

    // (2r + 2^J) * 2^J against the remainder
    assign trial = ((QW)'(part[k]) << (J + 1)) | ((QW)'(1) << (2 * J));
    assign take  = rem[k] >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= take ? rem[k] - trial : rem[k];
        part[k+1] <= take ? (part[k] | ((RW)'(1) << J)) : part[k];
      end
    end
  end

  assign root = part[RW];

endmodule

// ===== rtl/fbik_cordic.sv =====
// ----------------------------------------------------------------------------
// fbik_cordic
// Pipelined vectoring CORDIC: atan2(y, x) in Q30 radians, one quadrant
// stage and one stage per rotation step.
// ----------------------------------------------------------------------------
module fbik_cordic #(
  parameter int W = 64
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [W-1:0]           y,
  input  logic signed [W-1:0]           x,
  output logic signed [fbik_pkg::ZW-1:0] z
);

  import fbik_pkg::*;

  logic signed [W-1:0]  xs   [CORDIC_STEPS+1];
  logic signed [W-1:0]  ys   [CORDIC_STEPS+1];
  logic signed [ZW-1:0] zs   [CORDIC_STEPS+1];
  logic                 zero [CORDIC_STEPS+1];

  // fold the left half-plane onto the right
  always_ff @(posedge clk) begin
    if (en) begin
      zero[0] <= (x == '0) && (y == '0);
      if (x < 0) begin
        if (y >= 0) begin
          xs[0] <= y;
          ys[0] <= -x;
          zs[0] <= HALF_PI_Q30;
        end else begin
          xs[0] <= -y;
          ys[0] <= x;
          zs[0] <= -HALF_PI_Q30;
        end
      end else begin
        xs[0] <= x;
        ys[0] <= y;
        zs[0] <= '0;
      end
    end
  end

  // rotation steps
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    localparam logic signed [ZW-1:0] ANG = step_angle(k);
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;

    assign dx = ys[k] >>> k;
    assign dy = xs[k] >>> k;

    always_ff @(posedge clk) begin
      if (en) begin
        zero[k+1] <= zero[k];
        if (ys[k] > 0) begin
          xs[k+1] <= xs[k] + dx;
          ys[k+1] <= ys[k] - dy;
          zs[k+1] <= zs[k] + ANG;
        end else begin
          xs[k+1] <= xs[k] - dx;
          ys[k+1] <= ys[k] + dy;
          zs[k+1] <= zs[k] - ANG;
        end
      end
    end
  end

  assign z = zero[CORDIC_STEPS] ? '0 : zs[CORDIC_STEPS];

endmodule

// ===== rtl/fbik_side.sv =====
// ----------------------------------------------------------------------------
// fbik_side
// One crank: reachability test, normalization, discriminant, square root
// and the two arc tangents, combined into a wrapped Q30 angle.
// ----------------------------------------------------------------------------
module fbik_side (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [33:0]    u,
  input  logic signed [32:0]    v,
  input  logic [31:0]           a,
  input  logic [31:0]           b,
  input  logic                  pos,
  output fbik_pkg::side_out_t   res
);

  import fbik_pkg::*;

  function automatic logic [5:0] msb_pos(input logic [32:0] m);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 33; i++) begin
      if (m[i]) p = 6'(i);
    end
    return p;
  endfunction

  // stage 1: magnitudes, largest operand, reach bounds
  logic [32:0] ua_s1, va_s1, m_s1;
  logic [31:0] a_s1, b_s1, diff_s1;
  logic [33:0] sum_s1;
  logic        usg_s1, vsg_s1, pos_s1;
  logic [32:0] ua_c, va_c, m_c;

  assign ua_c = u[33] ? 33'(-u) : 33'(u);
  assign va_c = v[32] ? 33'(-v) : 33'(v);

  always_comb begin
    m_c = ua_c;
    if (va_c > m_c) m_c = va_c;
    if (33'(a) > m_c) m_c = 33'(a);
    if (33'(b) > m_c) m_c = 33'(b);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua_s1   <= ua_c;
      va_s1   <= va_c;
      m_s1    <= m_c;
      a_s1    <= a;
      b_s1    <= b;
      usg_s1  <= u[33];
      vsg_s1  <= v[32];
      pos_s1  <= pos;
      sum_s1  <= 34'(a) + 34'(b);
      diff_s1 <= (a > b) ? a - b : b - a;
    end
  end

  // reachability: squared distance strictly inside the annulus
  logic [67:0] pu, pv, pdiff, psum;
  logic [68:0] dsum;
  logic        reach_s4, reach_d;

  fbik_mul #(.W(34)) u_mul_ru (.clk, .en, .a({1'b0, ua_s1}), .b({1'b0, ua_s1}), .p(pu));
  fbik_mul #(.W(34)) u_mul_rv (.clk, .en, .a({1'b0, va_s1}), .b({1'b0, va_s1}), .p(pv));
  fbik_mul #(.W(34)) u_mul_rd (.clk, .en, .a({2'b0, diff_s1}), .b({2'b0, diff_s1}),
                               .p(pdiff));
  fbik_mul #(.W(34)) u_mul_rs (.clk, .en, .a(sum_s1), .b(sum_s1), .p(psum));

  assign dsum = 69'(pu) + 69'(pv);

  always_ff @(posedge clk) begin
    if (en) begin
      reach_s4 <= (69'(pdiff) < dsum) && (dsum < 69'(psum));
    end
  end

  fbik_delay #(.W(1), .N(99)) u_dly_reach (.clk, .en, .d(reach_s4), .q(reach_d));

  // stage 2: leading one of the largest operand
  logic [32:0] ua_s2, va_s2, a_s2, b_s2;
  logic [5:0]  msb_s2;
  logic        usg_s2, vsg_s2;

  always_ff @(posedge clk) begin
    if (en) begin
      ua_s2  <= ua_s1;
      va_s2  <= va_s1;
      a_s2   <= 33'(a_s1);
      b_s2   <= 33'(b_s1);
      usg_s2 <= usg_s1;
      vsg_s2 <= vsg_s1;
      msb_s2 <= msb_pos(m_s1);
    end
  end

  // stage 3: scale so the largest lies in [2^29, 2^30)
  logic [29:0]        ua_s3, va_s3, a_s3, b_s3;
  logic signed [33:0] us_s3, vs_s3;
  logic [5:0]         rsh, lsh;
  logic [29:0]        ua_n, va_n, a_n, b_n;

  assign rsh = msb_s2 - 6'd29;
  assign lsh = 6'd29 - msb_s2;

  always_comb begin
    if (msb_s2 >= 6'd30) begin
      ua_n = 30'(ua_s2 >> rsh);
      va_n = 30'(va_s2 >> rsh);
      a_n  = 30'(a_s2 >> rsh);
      b_n  = 30'(b_s2 >> rsh);
    end else begin
      ua_n = 30'(ua_s2 << lsh);
      va_n = 30'(va_s2 << lsh);
      a_n  = 30'(a_s2 << lsh);
      b_n  = 30'(b_s2 << lsh);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua_s3 <= ua_n;
      va_s3 <= va_n;
      a_s3  <= a_n;
      b_s3  <= b_n;
      us_s3 <= usg_s2 ? -$signed(34'(ua_n)) : $signed(34'(ua_n));
      vs_s3 <= vsg_s2 ? -$signed(34'(va_n)) : $signed(34'(va_n));
    end
  end

  // squares of the scaled values
  logic [59:0] puu, pvv, paa, pbb;

  fbik_mul #(.W(30)) u_mul_uu (.clk, .en, .a(ua_s3), .b(ua_s3), .p(puu));
  fbik_mul #(.W(30)) u_mul_vv (.clk, .en, .a(va_s3), .b(va_s3), .p(pvv));
  fbik_mul #(.W(30)) u_mul_aa (.clk, .en, .a(a_s3), .b(a_s3), .p(paa));
  fbik_mul #(.W(30)) u_mul_bb (.clk, .en, .a(b_s3), .b(b_s3), .p(pbb));

  // stage 6: d and T
  logic [60:0]        d_s6;
  logic signed [62:0] t_s6;
  logic [59:0]        bb_s6;

  always_ff @(posedge clk) begin
    if (en) begin
      d_s6  <= 61'(puu) + 61'(pvv);
      t_s6  <= $signed(63'(pbb) + 63'(puu) + 63'(pvv) - 63'(paa));
      bb_s6 <= pbb;
    end
  end

  // stage 7: |T| and operands of the discriminant products
  logic [61:0] tm_s7, lhsa_s7, d_s7;
  logic        tneg_s7;

  always_ff @(posedge clk) begin
    if (en) begin
      tneg_s7 <= t_s6[62];
      tm_s7   <= t_s6[62] ? 62'(-t_s6) : 62'(t_s6);
      lhsa_s7 <= {bb_s6, 2'b00};
      d_s7    <= {1'b0, d_s6};
    end
  end

  logic [123:0] lhs, rhs;

  fbik_mul #(.W(62)) u_mul_lhs (.clk, .en, .a(lhsa_s7), .b(d_s7), .p(lhs));
  fbik_mul #(.W(62)) u_mul_rhs (.clk, .en, .a(tm_s7), .b(tm_s7), .p(rhs));

  // stage 10: discriminant, negative clamps to zero
  logic [123:0] disc_s10;

  always_ff @(posedge clk) begin
    if (en) begin
      disc_s10 <= (rhs < lhs) ? lhs - rhs : '0;
    end
  end

  logic [61:0] root;

  fbik_sqrt #(.QW(124), .RW(62)) u_sqrt (.clk, .en, .radicand(disc_s10), .root(root));

  // side data aligned with the root; the branch select is aligned with the CORDIC outputs
  logic [62:0]        tpack_d;
  logic [67:0]        uv_d;
  logic               pos_d;
  logic signed [63:0] th, ch;
  logic signed [33:0] us_d, vs_d;

  fbik_delay #(.W(63), .N(65)) u_dly_t (.clk, .en, .d({tneg_s7, tm_s7}), .q(tpack_d));
  fbik_delay #(.W(68), .N(69)) u_dly_uv (.clk, .en, .d({us_s3, vs_s3}), .q(uv_d));
  fbik_delay #(.W(1), .N(102)) u_dly_pos (.clk, .en, .d(pos_s1), .q(pos_d));

  assign th   = tpack_d[62] ? -$signed(64'(tpack_d[61:1])) : $signed(64'(tpack_d[61:1]));
  assign ch   = $signed(64'(root[61:1]));
  assign us_d = $signed(uv_d[67:34]);
  assign vs_d = $signed(uv_d[33:0]);

  logic signed [ZW-1:0] psi, phi;

  fbik_cordic #(.W(64)) u_cordic_psi (.clk, .en, .y(ch), .x(th), .z(psi));
  fbik_cordic #(.W(34)) u_cordic_phi (.clk, .en, .y(vs_d), .x(us_d), .z(phi));

  // combine and wrap into (-pi, pi]
  logic signed [AW-1:0] ang, ang_w;

  always_comb begin
    ang   = pos_d ? AW'(phi) - AW'(psi) : AW'(phi) + AW'(psi);
    ang_w = ang;
    if (ang > PI_Q30) ang_w = ang - TWO_PI_Q30;
    else if (ang <= -PI_Q30) ang_w = ang + TWO_PI_Q30;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.angle <= ang_w;
      res.reach <= reach_d;
    end
  end

endmodule
